[hdl/bpm_pkg.sv]
// Shared types, register indexes and helpers for the byte pattern matcher.
`default_nettype none

package bpm_pkg;

	localparam int PAT_BYTES = 8;   // pattern register holds this many bytes
	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MATCH_MODE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 4'd3;

	localparam logic [1:0] MODE_EQUALS      = 2'd0;
	localparam logic [1:0] MODE_STARTS_WITH = 2'd1;
	localparam logic [1:0] MODE_ENDS_WITH   = 2'd2;
	localparam logic [1:0] MODE_CONTAINS    = 2'd3;

	typedef struct packed {
		logic [1:0]  match_mode;
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic        case_sensitive;
	} cfg_t;

	// one queued item, already classified
	typedef struct packed {
		logic [7:0] data;
		logic       is_byte;   // carries a buffer byte
		logic       is_end;    // closes the buffer, owes a result
	} item_t;

	// fold ASCII a-z to upper case unless compare is exact
	function automatic logic [7:0] fold(input logic [7:0] b, input logic exact);
		logic [7:0] r;
		r = b;
		if (!exact && b >= 8'h61 && b <= 8'h7A)
			r = b - 8'h20;
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/byte_pattern_matcher.sv]
// Top level: configuration registers, input queue and matcher.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_ready  | data_byte, last_byte, empty_buffer
//  out     | out_valid/out_ready| matched
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// One item per cycle sustained unless a held result stalls an ending item.
// A result appears in the cycle after its ending item leaves the two-entry queue.
// Reset clears the queue, buffer state and registers (case_sensitive to 1).
// A held result stalls only ending items; bytes keep flowing until the queue fills.
`default_nettype none

module byte_pattern_matcher #(
	parameter int PATTERN_MAX = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	input  wire logic        empty_buffer,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             matched,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	bpm_pkg::cfg_t  cfg_q;
	bpm_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_mode     <= bpm_pkg::MODE_EQUALS;
			cfg_q.pattern_bytes  <= '0;
			cfg_q.pattern_length <= '0;
			cfg_q.case_sensitive <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpm_pkg::REG_MATCH_MODE:     cfg_q.match_mode     <= cfg_data[1:0];
				bpm_pkg::REG_PATTERN_BYTES:  cfg_q.pattern_bytes  <= cfg_data;
				bpm_pkg::REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[3:0];
				bpm_pkg::REG_CASE_SENSITIVE: cfg_q.case_sensitive <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bpm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.empty_buffer (empty_buffer),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	bpm_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.matched   (matched)
	);

endmodule

`default_nettype wire

[hdl/bpm_front.sv]
// Input side: takes items, classifies them and queues them for the matcher.
`default_nettype none

module bpm_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	input  wire logic         empty_buffer,
	output logic              q_valid,
	output bpm_pkg::item_t    q_item,
	input  wire logic         q_pop
);

	bpm_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	bpm_pkg::item_t new_item;

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_comb begin
		new_item.data    = data_byte;
		new_item.is_byte = !empty_buffer;
		new_item.is_end  = empty_buffer || last_byte;
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= !rd_ptr_q;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2) else $error("queue count overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step");

endmodule

`default_nettype wire

[hdl/bpm_back.sv]
// Matcher: per-buffer window, prefix and anywhere tracking, result register.
`default_nettype none

module bpm_back #(
	parameter int PATTERN_MAX = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire bpm_pkg::cfg_t cfg,
	input  wire logic         q_valid,
	input  wire bpm_pkg::item_t q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic              matched
);

	localparam int CNT_W = $clog2(PATTERN_MAX + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PATTERN_MAX + 1);
	localparam logic [3:0] PMAX4 = 4'(PATTERN_MAX);

	logic [7:0]       win_q [PATTERN_MAX];
	logic [CNT_W-1:0] cnt_q;
	logic             prefix_q;
	logic             found_q;
	logic             out_valid_q;
	logic             matched_q;

	logic [7:0]       pat_f [bpm_pkg::PAT_BYTES];
	logic [7:0]       win_n [PATTERN_MAX];
	logic [CNT_W-1:0] cnt_n;
	logic             prefix_n;
	logic             found_n;
	logic [3:0]       n_eff;
	logic [7:0]       b_f;
	logic [PATTERN_MAX-1:0] lane_ok;
	logic             tail;
	logic             m;

	assign q_pop     = q_valid && (!q_item.is_end || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	always_comb begin
		n_eff = (cfg.pattern_length > PMAX4) ? PMAX4 : cfg.pattern_length;
		for (int k = 0; k < bpm_pkg::PAT_BYTES; k++)
			pat_f[k] = bpm_pkg::fold(cfg.pattern_bytes[8*k +: 8], cfg.case_sensitive);
		b_f = bpm_pkg::fold(q_item.data, cfg.case_sensitive);

		// window after this item, newest first
		for (int i = 0; i < PATTERN_MAX; i++)
			win_n[i] = win_q[i];
		cnt_n    = cnt_q;
		prefix_n = prefix_q;
		if (q_item.is_byte) begin
			win_n[0] = q_item.data;
			for (int i = 1; i < PATTERN_MAX; i++)
				win_n[i] = win_q[i-1];
			if (cnt_q < CNT_MAX)
				cnt_n = cnt_q + CNT_W'(1);
			if (4'(cnt_q) < n_eff && b_f != pat_f[3'(cnt_q)])
				prefix_n = 1'b0;
		end

		// newest byte lines up with the last pattern byte
		for (int i = 0; i < PATTERN_MAX; i++)
			lane_ok[i] = (4'(i) >= n_eff) ||
				(bpm_pkg::fold(win_n[i], cfg.case_sensitive) ==
				 pat_f[3'(n_eff - 4'd1 - 4'(i))]);
		tail = (4'(cnt_n) >= n_eff) && (&lane_ok);

		found_n = found_q || (q_item.is_byte && n_eff != 4'd0 && tail);

		unique case (cfg.match_mode)
			bpm_pkg::MODE_EQUALS:
				m = (n_eff == 4'd0) ? (cnt_n == '0) : (4'(cnt_n) == n_eff && prefix_n);
			bpm_pkg::MODE_STARTS_WITH:
				m = (n_eff != 4'd0) && (4'(cnt_n) >= n_eff) && prefix_n;
			bpm_pkg::MODE_ENDS_WITH:
				m = (n_eff != 4'd0) && tail;
			bpm_pkg::MODE_CONTAINS:
				m = (n_eff == 4'd0) || found_n;
			default:
				m = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.is_byte)
			for (int i = 0; i < PATTERN_MAX; i++)
				win_q[i] <= win_n[i];
		if (q_pop && q_item.is_end)
			matched_q <= m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			prefix_q    <= 1'b1;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.is_end) begin
					cnt_q    <= '0;
					prefix_q <= 1'b1;
					found_q  <= 1'b0;
				end else begin
					cnt_q    <= cnt_n;
					prefix_q <= prefix_n;
					found_q  <= found_n;
				end
			end
			if (q_pop && q_item.is_end)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("byte count past saturation");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_item.is_end) |=> (cnt_q == '0 && prefix_q && !found_q && out_valid_q))
		else $error("buffer state not cleared after end item");

	a_found_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (cnt_q != '0)) else $error("match found with no bytes");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(q_pop && q_item.is_end))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/tb_byte_pattern_matcher.sv]
`timescale 1ns / 1ps
// Testbench for byte_pattern_matcher: directed and random buffers, each result checked in order.

module tb_byte_pattern_matcher;

	localparam int PAT_MAX = 8;
	localparam int CLK_HALF = 6;
	localparam logic [3:0] REG_FIRST_UNUSED = 4'd4;
	localparam int MAX_PRINTED = 50;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty_buffer;
	logic        out_valid;
	logic        out_ready;
	logic        matched;
	logic        cfg_we;
	logic [3:0]  cfg_index;
	logic [63:0] cfg_data;

	// register copies as the block should hold them
	logic [1:0]  mode_r;
	logic [63:0] pat_r;
	logic [3:0]  len_r;
	logic        exact_r;

	// per-buffer matcher state
	logic [7:0]  win [PAT_MAX];
	logic [3:0]  seen_cnt;
	logic        prefix_good;
	logic        pattern_seen;

	logic        match_q [$];
	logic        want_match;
	int          err_cnt;
	int          items_sent;
	int          results_seen;
	int          send_idle_pct;
	int          recv_stall_pct;

	byte_pattern_matcher #(.PATTERN_MAX(PAT_MAX)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty_buffer(empty_buffer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [7:0] fold_up(input logic [7:0] b);
		if (!exact_r && b >= 8'h61 && b <= 8'h7A)
			return b - 8'h20;
		return b;
	endfunction

	function automatic int active_len();
		return (int'(len_r) > PAT_MAX) ? PAT_MAX : int'(len_r);
	endfunction

	function automatic logic [7:0] pat_at(input int i);
		return fold_up(pat_r[8*i +: 8]);
	endfunction

	// newest bytes end with the whole pattern
	function automatic logic tail_hit();
		int n;
		n = active_len();
		if (int'(seen_cnt) < n)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (fold_up(win[i]) != pat_at(n - 1 - i))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_buffer_state();
		for (int i = 0; i < PAT_MAX; i++)
			win[i] = 8'h00;
		seen_cnt = 4'd0;
		prefix_good = 1'b1;
		pattern_seen = 1'b0;
	endfunction

	function automatic void predict_match(input logic [7:0] d, input logic l, input logic e);
		int n;
		logic m;
		n = active_len();
		if (!e) begin
			if (int'(seen_cnt) < n && fold_up(d) != pat_at(int'(seen_cnt)))
				prefix_good = 1'b0;
			for (int i = PAT_MAX - 1; i > 0; i--)
				win[i] = win[i-1];
			win[0] = d;
			if (int'(seen_cnt) < PAT_MAX + 1)
				seen_cnt = seen_cnt + 4'd1;
			if (n > 0 && tail_hit())
				pattern_seen = 1'b1;
		end
		if (e || l) begin
			case (mode_r)
				bpm_pkg::MODE_EQUALS: begin
					m = (n == 0) ? (seen_cnt == 4'd0) : (int'(seen_cnt) == n && prefix_good);
				end
				bpm_pkg::MODE_STARTS_WITH: begin
					m = n > 0 && int'(seen_cnt) >= n && prefix_good;
				end
				bpm_pkg::MODE_ENDS_WITH: begin
					m = n > 0 && tail_hit();
				end
				default: begin
					m = (n == 0) || pattern_seen;
				end
			endcase
			match_q = {match_q, m};
			clear_buffer_state();
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (err_cnt < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (match_q.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				want_match = match_q.pop_front();
				if (matched !== want_match)
					report_mismatch($sformatf("result %0d: matched %b, expected %b",
						results_seen, matched, want_match));
			end
			results_seen++;
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_item(input logic [7:0] d, input logic l, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		data_byte = d;
		last_byte = l;
		empty_buffer = e;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_match(d, l, e);
		items_sent++;
	endtask

	// a zero-length buffer goes out as one empty item
	task automatic send_buffer(input logic [7:0] bytes [$], input logic close_empty);
		for (int i = 0; i < bytes.size(); i++)
			send_item(bytes[i], (i == bytes.size() - 1) && !close_empty, 1'b0);
		if (bytes.size() == 0 || close_empty)
			send_item(8'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic send_word(input logic [63:0] bytes, input int n);
		logic [7:0] q [$];
		for (int i = 0; i < n; i++)
			q = {q, bytes[8*i +: 8]};
		send_buffer(q, 1'b0);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (match_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			bpm_pkg::REG_MATCH_MODE:     mode_r = val[1:0];
			bpm_pkg::REG_PATTERN_BYTES:  pat_r = val;
			bpm_pkg::REG_PATTERN_LENGTH: len_r = val[3:0];
			bpm_pkg::REG_CASE_SENSITIVE: exact_r = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// unused upper data bits carry junk on purpose
	task automatic set_config(input logic [1:0] mode, input logic [63:0] pat,
		input logic [3:0] len, input logic exact);
		logic [63:0] junk;
		wait_idle();
		junk = {$urandom, $urandom};
		write_reg(bpm_pkg::REG_MATCH_MODE, {junk[63:2], mode});
		write_reg(bpm_pkg::REG_PATTERN_BYTES, pat);
		write_reg(bpm_pkg::REG_PATTERN_LENGTH, {junk[63:4], len});
		write_reg(bpm_pkg::REG_CASE_SENSITIVE, {junk[63:1], exact});
	endtask

	function automatic logic [7:0] pick_byte();
		int r;
		logic [7:0] b;
		logic [7:0] edge_vals [6];
		edge_vals = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B};
		r = $urandom_range(99);
		if (r < 45) begin
			b = 8'h41 + 8'($urandom_range(25));
			if ($urandom_range(1) == 1)
				b = b | 8'h20;
			return b;
		end
		if (r < 70)
			return 8'($urandom);
		return edge_vals[$urandom_range(5)];
	endfunction

	function automatic logic [7:0] maybe_flip(input logic [7:0] b);
		logic is_alpha;
		is_alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
		if (is_alpha && $urandom_range(1) == 1 && (!exact_r || $urandom_range(3) == 0))
			return b ^ 8'h20;
		return b;
	endfunction

	// filler often reuses pattern bytes so partial overlaps show up
	function automatic logic [7:0] filler_byte();
		int idx;
		if ($urandom_range(1) == 1)
			return pick_byte();
		idx = $urandom_range(PAT_MAX - 1);
		return maybe_flip(pat_r[8*idx +: 8]);
	endfunction

	task automatic test_reset_defaults();
		// empty pattern, equals: only the empty buffer matches
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
	endtask

	task automatic test_equals_zero_bytes();
		set_config(bpm_pkg::MODE_EQUALS, 64'hFF00_FF00_FF00_FF00, 4'd8, 1'b1);
		send_word(64'hFF00_FF00_FF00_FF00, 8);
	endtask

	task automatic test_suffix_and_contains();
		set_config(bpm_pkg::MODE_ENDS_WITH, 64'h4241, 4'd2, 1'b1);
		send_word(64'h42_41_78, 3);
		set_config(bpm_pkg::MODE_CONTAINS, 64'h4241, 4'd2, 1'b1);
		send_word(64'h78_42_41_78, 4);
	endtask

	task automatic test_empty_pattern();
		set_config(bpm_pkg::MODE_CONTAINS, {$urandom, $urandom}, 4'd0, 1'b1);
		send_word(64'h5A, 1);
		set_config(bpm_pkg::MODE_STARTS_WITH, {$urandom, $urandom}, 4'd0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
	endtask

	task automatic test_clamp_and_fold();
		// length above the maximum acts as the maximum; lower case pattern vs upper buffer
		set_config(bpm_pkg::MODE_STARTS_WITH, 64'h7A67_6665_6463_6261, 4'd15, 1'b0);
		send_word(64'h5A47_4645_4443_4241, 8);
	endtask

	task automatic test_empty_mid_buffer();
		// empty item after an open buffer closes it; its byte and last mark are ignored
		set_config(bpm_pkg::MODE_EQUALS, 64'h41, 4'd1, 1'b1);
		send_item(8'h41, 1'b0, 1'b0);
		send_item(8'h41, 1'b1, 1'b1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
		int target;
		int n;
		int head;
		int tail;
		int kind;
		int k;
		logic [7:0] buf_q [$];
		logic [3:0] len;
		logic [63:0] pat;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(9))
				0:       len = 4'd0;
				1, 2:    len = 4'(PAT_MAX);
				3:       len = 4'($urandom_range(PAT_MAX + 1, 15));
				default: len = 4'($urandom_range(1, PAT_MAX - 1));
			endcase
			for (int i = 0; i < PAT_MAX; i++)
				pat[8*i +: 8] = pick_byte();
			set_config(2'($urandom_range(3)), pat, len, 1'($urandom));
			if ($urandom_range(7) == 0)
				write_reg(4'($urandom_range(int'(REG_FIRST_UNUSED), 15)), {$urandom, $urandom});
			repeat ($urandom_range(6, 16)) begin
				if (items_sent >= target)
					break;
				n = active_len();
				kind = $urandom_range(9);
				head = 0;
				tail = 0;
				buf_q = {};
				case (kind)
					1:       tail = $urandom_range(1, 4);
					2:       head = $urandom_range(1, 4);
					3, 4: begin
						head = $urandom_range(3);
						tail = $urandom_range(3);
					end
					5:       head = $urandom_range(1);
					8, 9: begin
						head = $urandom_range(4);
						tail = $urandom_range(4);
					end
					default: ;
				endcase
				if (kind == 6) begin
					repeat ($urandom_range(1, 12)) buf_q = {buf_q, pick_byte()};
				end else if (kind != 7) begin
					repeat (head) buf_q = {buf_q, filler_byte()};
					for (int i = 0; i < n; i++)
						buf_q = {buf_q, maybe_flip(pat_r[8*i +: 8])};
					// near miss: one pattern bit flipped
					if (kind == 5 && n > 0) begin
						k = head + $urandom_range(n - 1);
						buf_q[k] = buf_q[k] ^ 8'(1 << $urandom_range(7));
					end
					repeat (tail) buf_q = {buf_q, filler_byte()};
				end
				send_buffer(buf_q, $urandom_range(9) == 0);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		empty_buffer = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bpm_pkg::REG_MATCH_MODE;
		cfg_data = 64'd0;
		mode_r = bpm_pkg::MODE_EQUALS;
		pat_r = 64'd0;
		len_r = 4'd0;
		exact_r = 1'b1;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clear_buffer_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_equals_zero_bytes();
		test_suffix_and_contains();
		test_empty_pattern();
		test_clamp_and_fold();
		test_empty_mid_buffer();

		test_random_traffic(0, 0, 200);
		test_random_traffic(50, 0, 210);
		test_random_traffic(0, 50, 210);
		test_random_traffic(31, 31, 210);

		wait_idle();
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && match_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
